// ===== rtl/core/nqat_pkg.sv =====
// Package for the nesting and quote aware tokenizer.
// Holds register indexes, config/state/result structs and sizing constants.
// No dependencies.
package nqat_pkg;

  localparam int unsigned DelimSlots = 4;
  localparam int unsigned RegSlots   = 4;
  localparam int unsigned NumSlots   = (DelimSlots < RegSlots) ? DelimSlots : RegSlots;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;
  localparam logic [7:0]  DepthMax   = 8'hFF;
  localparam logic [31:0] DelimReset = 32'd47;

  typedef enum logic [CfgIdxW-1:0] {
    RegDelim  = 3'd0,
    RegOpen   = 3'd1,
    RegClose  = 3'd2,
    RegQuote  = 3'd3,
    RegEscape = 3'd4
  } nqat_reg_e;

  typedef struct packed {
    logic [31:0] delim_chars;
    logic [7:0]  open_char;
    logic [7:0]  close_char;
    logic [7:0]  quote_char;
    logic [7:0]  escape_char;
  } nqat_cfg_t;

  typedef struct packed {
    logic [7:0] nest_depth;
    logic       inside_quote;
    logic [7:0] prev_quoted;
    logic       in_run;
    logic       at_start;
  } nqat_state_t;

  localparam nqat_state_t StateReset = '{
    nest_depth:   8'd0,
    inside_quote: 1'b0,
    prev_quoted:  8'd0,
    in_run:       1'b0,
    at_start:     1'b1
  };

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_separator;
    logic       starts_token;
    logic       text_done;
  } nqat_result_t;

endpackage

// ===== rtl/core/nqat_classify.sv =====
// Per-word classification: separator match, quote and nesting tracking.
// Pure combinational next-state and result logic. Depends on nqat_pkg.
module nqat_classify import nqat_pkg::*; (
  input  nqat_cfg_t    cfg_i,
  input  nqat_state_t  state_i,
  input  logic [7:0]   byte_i,
  input  logic         final_i,
  output nqat_state_t  state_o,
  output nqat_result_t result_o
);

  logic        match;
  logic        sep;
  logic        start;
  logic        quoted;
  logic        escaped;
  logic [7:0]  slot;
  nqat_state_t nxt;

  always_comb begin
    match = 1'b0;
    slot  = '0;
    for (int unsigned i = 0; i < NumSlots; i++) begin
      slot = cfg_i.delim_chars[8*i +: 8];
      if (slot != 8'd0 && slot == byte_i) match = 1'b1;
    end
  end

  always_comb begin
    nxt     = state_i;
    sep     = 1'b0;
    start   = 1'b0;
    quoted  = 1'b0;
    escaped = (cfg_i.escape_char != 8'd0) && (state_i.prev_quoted == cfg_i.escape_char);
    if (state_i.in_run && match) begin
      sep = 1'b1;
    end else begin
      nxt.in_run = 1'b0;
      if (cfg_i.quote_char != 8'd0) begin
        if (state_i.inside_quote) begin
          if (byte_i == cfg_i.quote_char && !escaped) begin
            nxt.inside_quote = 1'b0;
          end else begin
            nxt.prev_quoted = byte_i;
            quoted          = 1'b1;
          end
        end else if (byte_i == cfg_i.quote_char) begin
          nxt.inside_quote = 1'b1;
          nxt.prev_quoted  = byte_i;
        end
      end
      if (!quoted) begin
        if (byte_i != 8'd0) begin
          if (byte_i == cfg_i.open_char && nxt.nest_depth != DepthMax) begin
            nxt.nest_depth = nxt.nest_depth + 8'd1;
          end
          if (byte_i == cfg_i.close_char && nxt.nest_depth != 8'd0) begin
            nxt.nest_depth = nxt.nest_depth - 8'd1;
          end
        end
        sep = (nxt.nest_depth == 8'd0) && match;
      end
      if (sep) begin
        nxt.in_run = 1'b1;
      end else begin
        start = state_i.in_run || state_i.at_start;
      end
    end
    nxt.at_start = 1'b0;
    state_o = final_i ? StateReset : nxt;
  end

  assign result_o.out_byte     = sep ? 8'd0 : byte_i;
  assign result_o.is_separator = sep;
  assign result_o.starts_token = start;
  assign result_o.text_done    = final_i;

endmodule

// ===== rtl/core/nesting_quote_aware_tokenizer.sv =====
// Top level of the nesting and quote aware tokenizer.
// Input register, nqat_classify, result register and config registers.
// Depends on nqat_pkg and nqat_classify.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one text byte per word
//   plus final_byte_i marking the last byte of a text. Output channel
//   (out_valid_o / out_stall_i) returns one classified word per input word,
//   in order. A word is moved on an edge where valid is high and stall low.
//   Path: a word accepted into the input register is classified and
//   captured in the result register, from which the output is driven.
//   Throughput: one word per cycle while the receiver does not stall; the
//   tokenizer state (depth, quote, separator run) is updated in the single
//   classify stage between the input register and the result register.
//   When the receiver stalls, the result holds and the input register keeps
//   its word; in_stall_o rises only once the input register is also full.
//   Reset clears both stages, the tokenizer state and loads the register
//   defaults (delimiter '/', all other characters zero).
//   Config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once and
//   are meant for idle periods. Tokenizer state clears after a final byte.
module nesting_quote_aware_tokenizer import nqat_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          text_byte_i,
  input  logic                final_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                is_separator_o,
  output logic                starts_token_o,
  output logic                text_done_o
);

  nqat_cfg_t    cfg_q;
  nqat_state_t  state_q, state_d;
  nqat_result_t res_d, res_q;
  logic         in_vld_q, out_vld_q;
  logic [7:0]   in_byte_q;
  logic         in_final_q;
  logic         advance;
  logic         in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delim_chars <= DelimReset;
      cfg_q.open_char   <= 8'd0;
      cfg_q.close_char  <= 8'd0;
      cfg_q.quote_char  <= 8'd0;
      cfg_q.escape_char <= 8'd0;
    end else if (cfg_we_i) begin
      case (nqat_reg_e'(cfg_idx_i))
        RegDelim:  cfg_q.delim_chars <= cfg_wdata_i;
        RegOpen:   cfg_q.open_char   <= cfg_wdata_i[7:0];
        RegClose:  cfg_q.close_char  <= cfg_wdata_i[7:0];
        RegQuote:  cfg_q.quote_char  <= cfg_wdata_i[7:0];
        RegEscape: cfg_q.escape_char <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q  <= text_byte_i;
      in_final_q <= final_byte_i;
    end
  end

  nqat_classify u_classify (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .byte_i   (in_byte_q),
    .final_i  (in_final_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StateReset;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign out_byte_o     = res_q.out_byte;
  assign is_separator_o = res_q.is_separator;
  assign starts_token_o = res_q.starts_token;
  assign text_done_o    = res_q.text_done;

`ifndef NO_ASSERTIONS
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q))
    else $error("input stalled without a blocked word");

  a_sep_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.is_separator) |-> (res_q.out_byte == 8'd0 && !res_q.starts_token))
    else $error("separator word carries data or token start");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_final_q) |=> (state_q == StateReset))
    else $error("state not cleared after final byte");

  a_run_is_sep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !in_final_q) |=> (state_q.in_run == res_q.is_separator))
    else $error("separator run flag disagrees with last result");
`endif

endmodule
